>>> sv/itoa_pkg.sv
`timescale 1ns / 1ps
// Integer-to-ASCII formatter package: request/response structs, format codes,
// ASCII constants and the per-digit shift step. No dependencies.
package itoa_pkg;

  typedef enum logic [1:0] {
    FMT_SDEC = 2'd0,
    FMT_UDEC = 2'd1,
    FMT_HEX  = 2'd2,
    FMT_OCT  = 2'd3
  } fmt_e;

  typedef enum logic [1:0] {
    OW_16 = 2'd0,
    OW_32 = 2'd1,
    OW_64 = 2'd2,
    OW_RSVD = 2'd3
  } owidth_e;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] value;
    logic [1:0]  operand_width;
    logic        lower_case;
  } itoa_req_t;

  typedef struct packed {
    logic [6:0] char_out;
    logic       last_char;
  } itoa_rsp_t;

  localparam logic [6:0] ASCII_ZERO    = 7'h30;
  localparam logic [6:0] ASCII_LOWER_A = 7'h61;
  localparam logic [6:0] ASCII_UPPER_A = 7'h41;
  localparam logic [6:0] ASCII_MINUS   = 7'h2D;

  // One bit shifted into a digit cell: returns {carry_out, new_digit}.
  // Carry out depends only on the old digit, so cells update in parallel.
  function automatic logic [4:0] digit_step(logic [3:0] d, logic cin, logic [1:0] fmt);
    logic [4:0] t;
    logic       co;
    t  = {d, cin};
    co = 1'b0;
    case (fmt)
      FMT_HEX: begin
        co = d[3];
        t  = {1'b0, d[2:0], cin};
      end
      FMT_OCT: begin
        co = d[2];
        t  = {2'b00, d[1:0], cin};
      end
      default: begin
        co = (d >= 4'd5);
        if (co) begin
          t = t - 5'd10;
        end
      end
    endcase
    return {co, t[3:0]};
  endfunction

  function automatic logic [6:0] digit_ascii(logic [3:0] d, logic lower);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = ASCII_ZERO + {3'b000, d};
    end else begin
      c = (lower ? ASCII_LOWER_A : ASCII_UPPER_A) + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

>>> sv/integer_to_ascii_radix_formatter_core.sv
`timescale 1ns / 1ps
// Integer-to-ASCII formatter top level: bit-serial radix conversion into a
// row of digit cells, then character emission. Depends on itoa_pkg.
//
// Usage:
//   A request is taken when start is high and busy is low; req_i holds the
//   raw value, format, operand width and letter case. The block then stays
//   busy until the last character has been registered.
//   Each character leaves on rsp_o for exactly one cycle with rsp_valid_o
//   high, most significant first; last_char marks the final one. Signed
//   decimal sends '-' ahead of the magnitude when the value is negative.
// Sequence per request:
//   A load step, then conversion over W operand bits (W = 16, 32 capped at
//   VALUE_WIDTH, or VALUE_WIDTH for the 64-bit and reserved codes): each
//   cycle shifts one operand bit, MSB first, into all digit cells at once
//   (double-dabble for decimal, plain shift for hex and octal). Then the
//   scan skips the leading zero digits, one cell per cycle, keeping at least
//   one digit; a negative signed decimal then sends '-', and the digits
//   follow one per cycle.
// Reset clears the sequencer and output strobe; digit cells are loaded
// per request. The receiver cannot stall: every character is shown once.
// Numbers with more than DIGIT_SLOTS digits keep the low DIGIT_SLOTS.
module integer_to_ascii_radix_formatter_core
  import itoa_pkg::*;
#(
  parameter int VALUE_WIDTH = 64,
  parameter int DIGIT_SLOTS = 22
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  itoa_req_t req_i,
  output logic      rsp_valid_o,
  output itoa_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
  localparam int IDX_W = $clog2(DIGIT_SLOTS);
  localparam int W32   = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SCAN,
    ST_SIGN,
    ST_EMIT
  } state_e;

  state_e                 state_q;
  logic [VALUE_WIDTH-1:0] mag_q;      // operand, MSB aligned, shifted left
  logic [CNT_W-1:0]       bits_q;     // bits still to shift in
  logic [IDX_W-1:0]       idx_q;      // digit cell being scanned/emitted
  logic [1:0]             fmt_q;
  logic                   lower_q;
  logic                   neg_q;      // '-' pending
  logic                   ovf_q;      // digits beyond the top cell are nonzero
  logic                   rsp_valid_q;
  itoa_rsp_t              rsp_q;
  logic [3:0]             dig_q [DIGIT_SLOTS];

  // Load path
  logic [CNT_W-1:0]       wsel;
  logic [CNT_W-1:0]       sh;
  logic [VALUE_WIDTH-1:0] aligned;
  logic                   load_neg;
  logic [VALUE_WIDTH-1:0] load_mag;
  logic                   accept;

  // Per-cell digit-step logic
  logic [3:0]             dig_d  [DIGIT_SLOTS];
  logic [DIGIT_SLOTS-1:0] cout;
  logic [4:0]             step   [DIGIT_SLOTS];

  assign accept = start && (state_q == ST_IDLE);
  assign busy   = (state_q != ST_IDLE);

  always_comb begin
    unique case (req_i.operand_width)
      OW_16:   wsel = CNT_W'(16);
      OW_32:   wsel = CNT_W'(W32);
      default: wsel = CNT_W'(VALUE_WIDTH);
    endcase
    sh = CNT_W'(VALUE_WIDTH) - wsel;
    // Shifting left drops the bits above the operand width; the operand's
    // sign bit lands at the top. Negation commutes with the shift.
    aligned  = req_i.value[VALUE_WIDTH-1:0] << sh;
    load_neg = (req_i.cmd == FMT_SDEC) && aligned[VALUE_WIDTH-1];
    load_mag = load_neg ? (~aligned + VALUE_WIDTH'(1)) : aligned;
  end

  always_comb begin
    logic carry;
    carry = mag_q[VALUE_WIDTH-1];
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      step[i]  = digit_step(dig_q[i], carry, fmt_q);
      cout[i]  = step[i][4];
      dig_d[i] = step[i][3:0];
      carry    = step[i][4];
    end
  end

  // Digit cells: cleared per request, updated in parallel while converting.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DIGIT_SLOTS; i++) begin
      if (accept) begin
        dig_q[i] <= 4'd0;
      end else if (state_q == ST_CONV) begin
        dig_q[i] <= dig_d[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mag_q       <= '0;
      bits_q      <= '0;
      idx_q       <= '0;
      fmt_q       <= FMT_SDEC;
      lower_q     <= 1'b0;
      neg_q       <= 1'b0;
      ovf_q       <= 1'b0;
      rsp_valid_q <= 1'b0;
      rsp_q       <= '0;
    end else begin
      rsp_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            mag_q   <= load_mag;
            bits_q  <= wsel;
            fmt_q   <= req_i.cmd;
            lower_q <= req_i.lower_case;
            neg_q   <= load_neg;
            ovf_q   <= 1'b0;
            idx_q   <= IDX_W'(DIGIT_SLOTS - 1);
            state_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          mag_q  <= mag_q << 1;
          bits_q <= bits_q - CNT_W'(1);
          // The part above the top cell never shrinks, so a carry is sticky.
          if (cout[DIGIT_SLOTS-1]) begin
            ovf_q <= 1'b1;
          end
          if (bits_q == CNT_W'(1)) begin
            state_q <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Skip leading zeros unless the number was cut to the cell count.
          if (!ovf_q && (dig_q[idx_q] == 4'd0) && (idx_q != '0)) begin
            idx_q <= idx_q - IDX_W'(1);
          end else if (neg_q) begin
            state_q <= ST_SIGN;
          end else begin
            state_q <= ST_EMIT;
          end
        end
        ST_SIGN: begin
          rsp_valid_q     <= 1'b1;
          rsp_q.char_out  <= ASCII_MINUS;
          rsp_q.last_char <= 1'b0;
          neg_q           <= 1'b0;
          state_q         <= ST_EMIT;
        end
        ST_EMIT: begin
          rsp_valid_q     <= 1'b1;
          rsp_q.char_out  <= digit_ascii(dig_q[idx_q], lower_q);
          rsp_q.last_char <= (idx_q == '0);
          if (idx_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q - IDX_W'(1);
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
